>>> rtl/esfd_pkg.sv
// Shared types, codes and the hex digit decoder for the escaped file stream deframer.
// No dependencies; imported by esfd_step and the top level.
package esfd_pkg;

	localparam logic [7:0] ESC_CODE = 8'd27;
	localparam logic [7:0] CH_NAME  = 8'h4E; // 'N'
	localparam logic [7:0] CH_FILE  = 8'h46; // 'F'
	localparam logic [7:0] CH_BYTE  = 8'h42; // 'B'
	localparam logic [7:0] CH_IDLE  = 8'h45; // 'E'
	localparam logic [7:0] CH_END   = 8'h5A; // 'Z'

	typedef enum logic [1:0] {
		KIND_NAME  = 2'd0,
		KIND_DATA  = 2'd1,
		KIND_ERROR = 2'd2,
		KIND_END   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		MODE_IDLE     = 2'd0,
		MODE_FILENAME = 2'd1,
		MODE_FILEDATA = 2'd2,
		MODE_HALTED   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		PH_NONE = 2'd0,
		PH_ESC  = 2'd1,
		PH_HEX1 = 2'd2,
		PH_HEX2 = 2'd3
	} phase_t;

	typedef struct packed {
		mode_t      mode;
		phase_t     phase;
		logic [3:0] high_nibble;
	} dfr_state_t;

	typedef struct packed {
		logic       valid;
		kind_t      kind;
		logic [7:0] value;
	} dfr_result_t;

	// Non-hex characters decode as zero.
	function automatic logic [3:0] hex_nibble(input logic [7:0] ch);
		logic [3:0] n;
		n = 4'd0;
		if (ch >= 8'h30 && ch <= 8'h39) begin
			n = ch[3:0];
		end else if ((ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66)) begin
			n = ch[3:0] + 4'd9;
		end
		return n;
	endfunction

endpackage

>>> rtl/esfd_step.sv
// Next-state and result logic for one received byte of the deframer.
// Depends on esfd_pkg.
module esfd_step (
	input  esfd_pkg::dfr_state_t  cur,
	input  logic [7:0]            rx_byte,
	output esfd_pkg::dfr_state_t  nxt,
	output esfd_pkg::dfr_result_t res
);
	import esfd_pkg::*;

	logic [7:0] emit_val;
	logic       emit_en;

	always_comb begin
		nxt       = cur;
		res.valid = 1'b0;
		res.kind  = KIND_NAME;
		res.value = 8'd0;
		emit_en   = 1'b0;
		emit_val  = rx_byte;

		if (cur.mode != MODE_HALTED) begin
			unique case (cur.phase)
				PH_NONE: begin
					if (rx_byte == ESC_CODE) begin
						nxt.phase = PH_ESC;
					end else begin
						emit_en = 1'b1;
					end
				end
				PH_ESC: begin
					nxt.phase = PH_NONE;
					priority if (rx_byte == CH_NAME) begin
						nxt.mode = MODE_FILENAME;
					end else if (rx_byte == CH_FILE) begin
						nxt.mode = MODE_FILEDATA;
					end else if (rx_byte == CH_IDLE) begin
						nxt.mode = MODE_IDLE;
					end else if (rx_byte == CH_BYTE) begin
						nxt.phase = PH_HEX1;
					end else if (rx_byte == CH_END) begin
						nxt.mode  = MODE_HALTED;
						res.valid = 1'b1;
						res.kind  = KIND_END;
					end else begin
						nxt.mode  = MODE_HALTED;
						res.valid = 1'b1;
						res.kind  = KIND_ERROR;
						res.value = rx_byte;
					end
				end
				PH_HEX1: begin
					nxt.high_nibble = hex_nibble(rx_byte);
					nxt.phase       = PH_HEX2;
				end
				PH_HEX2: begin
					nxt.phase = PH_NONE;
					emit_en   = 1'b1;
					emit_val  = {cur.high_nibble, hex_nibble(rx_byte)};
				end
				default: nxt.phase = PH_NONE;
			endcase
		end

		// Drop emitted bytes while idle.
		if (emit_en && cur.mode == MODE_FILENAME) begin
			res.valid = 1'b1;
			res.kind  = KIND_NAME;
			res.value = emit_val;
		end else if (emit_en && cur.mode == MODE_FILEDATA) begin
			res.valid = 1'b1;
			res.kind  = KIND_DATA;
			res.value = emit_val;
		end
	end

endmodule

>>> rtl/escaped_file_stream_deframer_top.sv
// Top level of the escaped file stream deframer: input register, step logic, result register.
// Depends on esfd_pkg and esfd_step.

// One received byte enters per transaction on the slave side; the block takes a new byte
// every cycle as long as the result register is free or being drained, so the sustained
// rate is one byte per clock. From input transaction to result, the byte is registered
// (s1), the escape state machine in esfd_step decides in one pass, and any result lands
// in the output register. ESC 'N' and ESC 'F' select filename or file-data mode, ESC 'E'
// returns to idle, ESC 'B' takes the next two bytes as hex digits (non-hex digits count
// as zero), plain bytes are passed in the current mode and dropped while idle. ESC 'Z'
// gives a batch-end result, any other escape code gives an error result carrying that
// code; after either, the block swallows all input until reset. Bytes that produce no
// result are consumed at the full rate too, while the result register is free or drained.
module escaped_file_stream_deframer_top (
	input  logic       clk,
	input  logic       arst_n,
	// slave side
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] rx_byte
	// master side
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] value
	output logic [1:0] m_tuser    // [1:0] kind
);
	import esfd_pkg::*;

	logic        valid_s1;
	logic [7:0]  rx_s1;
	dfr_state_t  state_q;
	dfr_state_t  state_nxt;
	dfr_result_t res;
	logic        m_tvalid_q;
	logic [7:0]  value_q;
	kind_t       kind_q;
	logic        out_free;

	// Result register can take a new entry when empty or being drained this cycle.
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = !valid_s1 || out_free;

	esfd_step u_step (
		.cur     (state_q),
		.rx_byte (rx_s1),
		.nxt     (state_nxt),
		.res     (res)
	);

	// Input register: hold the byte until the step logic can retire it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			rx_s1 <= s_tdata;
		end
	end

	// Escape state: advance only when the registered byte retires.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{mode: MODE_IDLE, phase: PH_NONE, high_nibble: 4'd0};
		end else if (valid_s1 && out_free) begin
			state_q <= state_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_free) begin
			m_tvalid_q <= valid_s1 && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1 && res.valid) begin
			value_q <= res.value;
			kind_q  <= res.kind;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = value_q;
	assign m_tuser  = kind_q;

	// Halted is sticky until reset.
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.mode == MODE_HALTED |=> state_q.mode == MODE_HALTED)
		else $error("halted mode left without reset");

	// A terminating result is only shown once the state machine has halted.
	a_term_halts: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && (kind_q == KIND_END || kind_q == KIND_ERROR)
		|-> state_q.mode == MODE_HALTED)
		else $error("end or error result without halting");

	// Once halted and the result register drains, nothing new appears.
	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.mode == MODE_HALTED && out_free |=> !m_tvalid_q)
		else $error("result produced while halted");

endmodule

>>> tb/tb.sv
// Self-checking testbench for escaped_file_stream_deframer_top: drives escaped byte streams
// on the slave side and checks every filename, data, error and batch-end result.
// Depends on esfd_pkg and the RTL under rtl/.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import esfd_pkg::*;

	// Holds the expected deframer state and the results that are still due on the master side.
	class deframe_ledger;
		typedef struct {
			kind_t      kind;
			logic [7:0] value;
		} deframed_t;

		mode_t      mode;
		phase_t     phase;
		logic [3:0] hi_digit;
		deframed_t  due[$];
		int         mismatches;
		int         names_seen;
		int         data_seen;
		int         bytes_taken;

		function new();
			mode = MODE_IDLE;
			phase = PH_NONE;
			hi_digit = 4'd0;
			mismatches = 0;
			names_seen = 0;
			data_seen = 0;
			bytes_taken = 0;
		endfunction

		// Digits 0-9, A-F and a-f; anything else counts as zero.
		function logic [3:0] digit_value(logic [7:0] ch);
			logic [7:0] v;
			v = 8'd0;
			if (ch >= "0" && ch <= "9") begin
				v = ch - "0";
			end else if (ch >= "A" && ch <= "F") begin
				v = ch - "A" + 8'd10;
			end else if (ch >= "a" && ch <= "f") begin
				v = ch - "a" + 8'd10;
			end
			return v[3:0];
		endfunction

		function void queue_result(kind_t kind, logic [7:0] value);
			deframed_t r;
			r.kind = kind;
			r.value = value;
			due.push_back(r);
		endfunction

		// Pass a byte in the current mode; drop it while idle.
		function void deliver(logic [7:0] b);
			if (mode == MODE_FILENAME) begin
				queue_result(KIND_NAME, b);
			end else if (mode == MODE_FILEDATA) begin
				queue_result(KIND_DATA, b);
			end
		endfunction

		// Advance the expected state by one accepted input transaction.
		function void take_byte(logic [7:0] b);
			bytes_taken++;
			if (mode == MODE_HALTED) begin
				return;
			end
			case (phase)
				PH_NONE: begin
					if (b == ESC_CODE) begin
						phase = PH_ESC;
					end else begin
						deliver(b);
					end
				end
				PH_ESC: begin
					phase = PH_NONE;
					case (b)
						CH_NAME: mode = MODE_FILENAME;
						CH_FILE: mode = MODE_FILEDATA;
						CH_IDLE: mode = MODE_IDLE;
						CH_BYTE: phase = PH_HEX1;
						CH_END: begin
							mode = MODE_HALTED;
							queue_result(KIND_END, 8'd0);
						end
						default: begin
							mode = MODE_HALTED;
							queue_result(KIND_ERROR, b);
						end
					endcase
				end
				PH_HEX1: begin
					hi_digit = digit_value(b);
					phase = PH_HEX2;
				end
				default: begin
					phase = PH_NONE;
					deliver({hi_digit, digit_value(b)});
				end
			endcase
		endfunction

		// Compare one output transaction against the oldest pending result.
		function void match_result(logic [1:0] kind, logic [7:0] value);
			deframed_t oldest;
			if (due.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result kind %0d value %02h, nothing pending",
					$time, kind, value);
				return;
			end
			oldest = due.pop_front();
			if (kind != oldest.kind) begin
				mismatches++;
				$display("%0t: kind mismatch, expected %0d actual %0d", $time, oldest.kind, kind);
			end
			if (value != oldest.value) begin
				mismatches++;
				$display("%0t: value mismatch, expected %02h actual %02h",
					$time, oldest.value, value);
			end
			if (oldest.kind == KIND_NAME) begin
				names_seen++;
			end else if (oldest.kind == KIND_DATA) begin
				data_seen++;
			end
		endfunction
	endclass

	localparam int CYCLE_LIMIT = 300000;
	localparam int PHASE_ITEMS = 330;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'd0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic [1:0] m_tuser;

	deframe_ledger ledger = new();
	int            tx_idle_pct = 0;
	int            rx_idle_pct = 0;
	int            hold_left = 0;
	int            cycles = 0;
	string         closing = "none";

	escaped_file_stream_deframer_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("escaped_file_stream_deframer_top verification failed");
			$finish;
		end
	end

	// Master side: check each result transaction using the values seen just before the
	// edge, then pick tready for the next cycle. A long hold is counted down here while
	// the sender keeps offering bytes, so the block backs up and drops s_tready.
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			ledger.match_result(m_tuser, m_tdata);
		end
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// Offer one byte, idling first at the current sender rate, and hold it until the
	// block takes the transaction. s_tvalid stays high on return so back-to-back bytes
	// never see it dropped and raised in the same step.
	task automatic put_byte(logic [7:0] b);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		ledger.take_byte(b);
	endtask

	task automatic put_escape(logic [7:0] code);
		put_byte(ESC_CODE);
		put_byte(code);
	endtask

	task automatic put_hex(logic [7:0] hi_ch, logic [7:0] lo_ch);
		put_escape(CH_BYTE);
		put_byte(hi_ch);
		put_byte(lo_ch);
	endtask

	// Mostly real hex digits; sometimes any byte, ESC included, to hit the zero fallback.
	function automatic logic [7:0] pick_digit();
		string digits;
		digits = "0123456789abcdefABCDEF";
		if ($urandom_range(0, 4) == 0) begin
			return 8'($urandom_range(0, 255));
		end
		return digits[$urandom_range(0, 21)];
	endfunction

	// Well-formed escape traffic with random content: plain bytes (never a bare ESC),
	// mode switches and hex-coded bytes. Halting codes are kept for the very end.
	task automatic random_traffic(int n);
		int         sent;
		int         pick;
		logic [7:0] b;
		sent = 0;
		while (sent < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				do b = 8'($urandom_range(0, 255)); while (b == ESC_CODE);
				put_byte(b);
				sent += 1;
			end else if (pick < 65) begin
				put_escape(CH_NAME);
				sent += 2;
			end else if (pick < 75) begin
				put_escape(CH_FILE);
				sent += 2;
			end else if (pick < 80) begin
				put_escape(CH_IDLE);
				sent += 2;
			end else begin
				put_hex(pick_digit(), pick_digit());
				sent += 4;
			end
		end
	endtask

	// Close the stream with either a batch end or an unknown escape code, then show that
	// everything after it is swallowed.
	task automatic close_stream();
		logic [7:0] code;
		if ($urandom_range(0, 1) == 0) begin
			closing = "batch end";
			put_escape(CH_END);
		end else begin
			closing = "unknown escape error";
			if ($urandom_range(0, 1) == 0) begin
				code = ESC_CODE;
			end else begin
				do code = 8'($urandom_range(0, 255));
				while (code == CH_NAME || code == CH_FILE || code == CH_IDLE ||
					code == CH_BYTE || code == CH_END);
			end
			put_escape(code);
		end
		put_escape(CH_FILE);
		put_byte(8'h5A);
		put_hex("1", "2");
		repeat (6) put_byte(8'($urandom_range(0, 255)));
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, both modes, idle dropping, hex digit cases.
		put_escape(CH_FILE);
		put_byte(8'h00);
		put_byte(8'hFF);
		put_hex("f", "0");
		put_hex("G", "9");               // non-hex high digit reads as zero
		put_escape(CH_NAME);
		put_hex(ESC_CODE, ESC_CODE);     // ESC taken as a hex digit, not an escape
		put_byte(8'h80);
		put_escape(CH_IDLE);
		put_byte(8'h55);                 // dropped while idle
		put_hex("A", "c");               // decoded but dropped while idle
		put_escape(CH_FILE);

		// Sender idles lightly, receiver heavily.
		tx_idle_pct = 28;
		rx_idle_pct = 46;
		random_traffic(PHASE_ITEMS);

		// Swap the pressure.
		tx_idle_pct = 46;
		rx_idle_pct = 28;
		random_traffic(PHASE_ITEMS);

		// Full rate on both sides, opened by a long receiver stall in data mode.
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		put_escape(CH_FILE);
		hold_left = 64;
		random_traffic(PHASE_ITEMS);

		close_stream();
		s_tvalid <= 1'b0;

		// Drain, then allow the pipeline latency for any stray result.
		while (ledger.due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("Covered %0d input bytes giving %0d filename and %0d file data bytes;",
			ledger.bytes_taken, ledger.names_seen, ledger.data_seen);
		$display("stream closed by %s, with stalls on both sides and at full rate.", closing);
		if (ledger.mismatches == 0 && ledger.due.size() == 0) begin
			$display("escaped_file_stream_deframer_top verification clean");
		end else begin
			$display("escaped_file_stream_deframer_top verification failed");
		end
		$finish;
	end
endmodule
